[rtl/rtpfu_pkg.sv]
// Shared types and constants for the RTP H.264 FU-A depacketizer.
`default_nettype none
package rtpfu_pkg;

   // Oversize limit on the packet byte position
   localparam logic [15:0] MAX_PACKET_BYTES = 16'hffff;
   localparam logic [6:0]  HEADER_BYTES_RESET = 7'd12;
   localparam logic [4:0]  FU_A_TYPE = 5'h1c;

   // Command queue between front and back
   localparam int unsigned CMD_DEPTH = 4;
   localparam int unsigned CMD_AW = $clog2(CMD_DEPTH);

   // Start burst: 00 00 00 01 then the NAL header on the last step
   localparam logic [2:0] START_ONE_STEP = 3'd3;
   localparam logic [2:0] START_LAST_STEP = 3'd4;

   typedef enum logic [1:0] {
      STATUS_DATA  = 2'd0,
      STATUS_SHORT = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      CMD_SINGLE = 1'b0,
      CMD_START  = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        out_last;
      status_type  status;
      logic [4:0]  nal_type;
      logic [2:0]  fragment_bits;
      logic [15:0] sequence_res;
      logic [31:0] timestamp;
   } rsp_type;

   // One classified packet byte: a single result or a five-result start burst
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
      logic         last;
      status_type   status;
      logic [4:0]   nal_type;
      logic [2:0]   fragment_bits;
      logic [15:0]  sequence_res;
      logic [31:0]  timestamp;
   } cmd_type;

endpackage
`default_nettype wire

[rtl/rtpfu_front.sv]
// Front part: tracks packet position, captures header fields, classifies each byte.
`default_nettype none
module rtpfu_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire rtpfu_pkg::req_type req_data,
   input  wire logic [6:0]        header_bytes,
   output rtpfu_pkg::cmd_type     cmd,
   output logic                   cmd_push
);

   localparam logic [15:0] MAX_PACKET_BYTES_L = rtpfu_pkg::MAX_PACKET_BYTES;

   logic [15:0] pos_ff, pos_in;
   logic [15:0] seq_ff, seq_in;
   logic [31:0] time_ff, time_in;
   logic [7:0]  ind_ff, ind_in;
   logic [2:0]  frag_ff, frag_in;

   logic [15:0] hb;
   logic        is_skip, is_hdr, is_fu_hdr;
   logic [7:0]  b;
   logic        last;

   assign b    = req_data.in_byte;
   assign last = req_data.in_last;
   assign hb   = {9'd0, header_bytes};

   // Classify the byte and capture header fields
   always_comb begin
      seq_in  = seq_ff;
      time_in = time_ff;
      ind_in  = ind_ff;
      frag_in = frag_ff;
      pos_in  = pos_ff;

      case (pos_ff)
         16'd2: seq_in[15:8] = b;
         16'd3: seq_in[7:0] = b;
         16'd4: time_in[31:24] = b;
         16'd5: time_in[23:16] = b;
         16'd6: time_in[15:8] = b;
         16'd7: time_in[7:0] = b;
         default: ;
      endcase

      is_skip   = (pos_ff == MAX_PACKET_BYTES_L) || (pos_ff < hb);
      is_hdr    = !is_skip && (pos_ff == hb);
      is_fu_hdr = !is_skip && !is_hdr && (pos_ff == hb + 16'd1) &&
                  (ind_ff[4:0] == rtpfu_pkg::FU_A_TYPE);

      if (is_hdr) begin
         ind_in = b;
      end
      if (is_fu_hdr) begin
         frag_in = b[7:5];
      end

      cmd.kind          = rtpfu_pkg::CMD_SINGLE;
      cmd.data          = 8'd0;
      cmd.last          = last;
      cmd.status        = rtpfu_pkg::STATUS_DATA;
      cmd.nal_type      = ind_in[4:0];
      cmd.fragment_bits = frag_in;
      cmd.sequence_res  = seq_in;
      cmd.timestamp     = time_in;
      cmd_push          = 1'b0;

      if (is_skip) begin
         cmd.status = rtpfu_pkg::STATUS_SHORT;
         cmd_push   = last;
      end else if (is_hdr) begin
         if (b[4:0] == rtpfu_pkg::FU_A_TYPE) begin
            cmd.status = rtpfu_pkg::STATUS_SHORT;
            cmd_push   = last;
         end else begin
            cmd.kind = rtpfu_pkg::CMD_START;
            cmd.data = b;
            cmd_push = 1'b1;
         end
      end else if (is_fu_hdr) begin
         if (b[7:6] == 2'b10) begin
            cmd.kind = rtpfu_pkg::CMD_START;
            cmd.data = {ind_ff[7:5], b[4:0]};
            cmd_push = 1'b1;
         end else begin
            cmd.status = rtpfu_pkg::STATUS_EMPTY;
            cmd_push   = last;
         end
      end else begin
         cmd.data = b;
         cmd_push = 1'b1;
      end
      cmd_push = cmd_push && accept;

      // Close the packet or advance the position
      if (last) begin
         pos_in  = 16'd0;
         ind_in  = 8'd0;
         frag_in = 3'd0;
      end else if (pos_ff != MAX_PACKET_BYTES_L) begin
         pos_in = pos_ff + 16'd1;
      end
   end

   // Hold state until a byte is accepted
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= 16'd0;
         seq_ff  <= 16'd0;
         time_ff <= 32'd0;
         ind_ff  <= 8'd0;
         frag_ff <= 3'd0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         seq_ff  <= seq_in;
         time_ff <= time_in;
         ind_ff  <= ind_in;
         frag_ff <= frag_in;
      end
   end

endmodule
`default_nettype wire

[rtl/rtpfu_cmd_fifo.sv]
// Short command queue between the front and back parts.
`default_nettype none
module rtpfu_cmd_fifo (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire rtpfu_pkg::cmd_type push_data,
   output logic                    full,
   input  wire logic               pop,
   output logic                    valid,
   output rtpfu_pkg::cmd_type      head
);

   localparam int unsigned AW = rtpfu_pkg::CMD_AW;
   localparam logic [AW:0] DEPTH = (AW + 1)'(rtpfu_pkg::CMD_DEPTH);

   rtpfu_pkg::cmd_type    slot_ff [rtpfu_pkg::CMD_DEPTH];
   logic [AW-1:0]         wr_ptr_ff, rd_ptr_ff;
   logic [AW:0]           count_ff;
   logic                  do_push, do_pop;

   assign full    = (count_ff == DEPTH);
   assign valid   = (count_ff != '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   // Write the new command
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + AW'(1);
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + (AW + 1)'(1);
            2'b01:   count_ff <= count_ff - (AW + 1)'(1);
            default: ;
         endcase
      end
   end

endmodule
`default_nettype wire

[rtl/rtpfu_back.sv]
// Back part: expands commands into result words and holds the output register.
`default_nettype none
module rtpfu_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               cmd_valid,
   input  wire rtpfu_pkg::cmd_type cmd,
   output logic                    cmd_pop,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output rtpfu_pkg::rsp_type      rsp_data
);

   logic               out_valid_ff, out_valid_in;
   rtpfu_pkg::rsp_type out_ff, out_in;
   logic [2:0]         step_ff, step_in;
   logic               load;

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign load      = cmd_valid && (!out_valid_ff || rsp_pop);

   // Build the next result word from the head command
   always_comb begin
      cmd_pop      = 1'b0;
      step_in      = step_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      if (load) begin
         out_valid_in         = 1'b1;
         out_in.nal_type      = cmd.nal_type;
         out_in.fragment_bits = cmd.fragment_bits;
         out_in.sequence_res  = cmd.sequence_res;
         out_in.timestamp     = cmd.timestamp;
         unique case (cmd.kind)
            rtpfu_pkg::CMD_SINGLE: begin
               out_in.out_byte = cmd.data;
               out_in.out_last = cmd.last;
               out_in.status   = cmd.status;
               cmd_pop         = 1'b1;
            end
            rtpfu_pkg::CMD_START: begin
               out_in.status = rtpfu_pkg::STATUS_DATA;
               if (step_ff == rtpfu_pkg::START_LAST_STEP) begin
                  out_in.out_byte = cmd.data;
                  out_in.out_last = cmd.last;
                  cmd_pop         = 1'b1;
                  step_in         = 3'd0;
               end else begin
                  out_in.out_byte = (step_ff == rtpfu_pkg::START_ONE_STEP) ? 8'd1 : 8'd0;
                  out_in.out_last = 1'b0;
                  step_in         = step_ff + 3'd1;
               end
            end
            default: ;
         endcase
      end
   end

   // Hold the output word until popped
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         step_ff      <= 3'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
      end
      out_ff <= out_in;
   end

endmodule
`default_nettype wire

[rtl/rtp_h264_fu_depacketizer_core.sv]
// Top level of the RTP H.264 FU-A depacketizer: front, command queue, back.
//
//   channel | ports                          | accepted when
//   --------+--------------------------------+------------------------
//   input   | req_push, req_full, req_data   | req_push && !req_full
//   result  | rsp_empty, rsp_pop, rsp_data   | rsp_pop && !rsp_empty
//   config  | csr_write, csr_data            | csr_write
//
// One packet byte is taken per cycle while the four-entry command queue has room.
// A byte's first result word is held in the command queue and then in the back output
// register before it reaches the result ports; a start word expands into five result words,
// one per cycle while the result side pops, from the back output register.
// Synchronous reset clears position, captured fields, queue and output; no clearing pass.
// A stalled result side fills the queue, then req_full rises.
`default_nettype none
module rtp_h264_fu_depacketizer_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire rtpfu_pkg::req_type req_data,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output rtpfu_pkg::rsp_type      rsp_data,
   input  wire logic               csr_write,
   input  wire logic [6:0]         csr_data
);

   logic [6:0]         header_bytes_ff;
   logic               accept;
   logic               cmd_push, cmd_pop, cmd_valid;
   rtpfu_pkg::cmd_type cmd_in, cmd_head;

   assign accept = req_push && !req_full;

   // Hold the header length register
   always_ff @(posedge clock) begin
      if (reset) begin
         header_bytes_ff <= rtpfu_pkg::HEADER_BYTES_RESET;
      end else if (csr_write) begin
         header_bytes_ff <= csr_data;
      end
   end

   rtpfu_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_data     (req_data),
      .header_bytes (header_bytes_ff),
      .cmd          (cmd_in),
      .cmd_push     (cmd_push)
   );

   rtpfu_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (req_full),
      .pop       (cmd_pop),
      .valid     (cmd_valid),
      .head      (cmd_head)
   );

   rtpfu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for the RTP H.264 FU-A depacketizer core.
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] FU_START_BITS = 2'b10;
   localparam logic [1:0] FU_END_BITS   = 2'b01;
   localparam int         MAX_REPORTS   = 100;

   typedef struct {
      logic [7:0]            b;
      logic                  l;
      bit                    typed;
      logic [7:0]            xb;
      logic                  xl;
      rtpfu_pkg::status_type xs;
      int                    set_hb;
   } pkt_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   rtpfu_pkg::req_type req_data = '0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   rtpfu_pkg::rsp_type rsp_data;
   logic               csr_write = 1'b0;
   logic [6:0]         csr_data = '0;

   // Depacketizer state as predicted
   logic [6:0]  hb_m   = rtpfu_pkg::HEADER_BYTES_RESET;
   logic [15:0] pos_m  = '0;
   logic [15:0] seq_m  = '0;
   logic [31:0] ts_m   = '0;
   logic [7:0]  ind_m  = '0;
   logic [2:0]  frag_m = '0;

   rtpfu_pkg::rsp_type words_due[$];
   pkt_row_type        rows[$];
   bit                 no_idle = 1'b0;
   int                 err_count = 0;
   int                 pkt_count = 0;
   int                 bytes_in = 0;
   int                 words_out = 0;
   int                 mid_hb;

   rtp_h264_fu_depacketizer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_data  (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   // Queue one expected Annex B word tagged with the current packet fields
   function automatic void due_word(logic [7:0] b, logic l, rtpfu_pkg::status_type s);
      rtpfu_pkg::rsp_type w;
      w.out_byte      = b;
      w.out_last      = l;
      w.status        = s;
      w.nal_type      = ind_m[4:0];
      w.fragment_bits = frag_m;
      w.sequence_res  = seq_m;
      w.timestamp     = ts_m;
      words_due.push_back(w);
   endfunction

   // Start code 00 00 00 01, then the NAL header
   function automatic void due_start(logic [7:0] hdr, logic l);
      due_word(8'h00, 1'b0, rtpfu_pkg::STATUS_DATA);
      due_word(8'h00, 1'b0, rtpfu_pkg::STATUS_DATA);
      due_word(8'h00, 1'b0, rtpfu_pkg::STATUS_DATA);
      due_word(8'h01, 1'b0, rtpfu_pkg::STATUS_DATA);
      due_word(hdr, l, rtpfu_pkg::STATUS_DATA);
   endfunction

   // Advance the predicted depacketizer by one packet byte
   function automatic void depacketize_byte(rtpfu_pkg::req_type r);
      logic [15:0] p;
      logic [15:0] hb16;
      p = pos_m;
      hb16 = {9'd0, hb_m};
      // capture goes by position alone, header length does not matter
      case (p)
         16'd2: seq_m[15:8] = r.in_byte;
         16'd3: seq_m[7:0]  = r.in_byte;
         16'd4: ts_m[31:24] = r.in_byte;
         16'd5: ts_m[23:16] = r.in_byte;
         16'd6: ts_m[15:8]  = r.in_byte;
         16'd7: ts_m[7:0]   = r.in_byte;
         default: ;
      endcase
      if (p == rtpfu_pkg::MAX_PACKET_BYTES || p < hb16) begin
         if (r.in_last) due_word(8'h00, 1'b1, rtpfu_pkg::STATUS_SHORT);
      end else if (p == hb16) begin
         ind_m = r.in_byte;
         if (r.in_byte[4:0] == rtpfu_pkg::FU_A_TYPE) begin
            if (r.in_last) due_word(8'h00, 1'b1, rtpfu_pkg::STATUS_SHORT);
         end else begin
            due_start(r.in_byte, r.in_last);
         end
      end else if (p == hb16 + 16'd1 && ind_m[4:0] == rtpfu_pkg::FU_A_TYPE) begin
         frag_m = r.in_byte[7:5];
         if (r.in_byte[7:6] == FU_START_BITS) begin
            due_start({ind_m[7:5], r.in_byte[4:0]}, r.in_last);
         end else if (r.in_last) begin
            due_word(8'h00, 1'b1, rtpfu_pkg::STATUS_EMPTY);
         end
      end else begin
         due_word(r.in_byte, r.in_last, rtpfu_pkg::STATUS_DATA);
      end
      if (r.in_last) begin
         pos_m  = '0;
         ind_m  = '0;
         frag_m = '0;
      end else if (p != rtpfu_pkg::MAX_PACKET_BYTES) begin
         pos_m = p + 16'd1;
      end
   endfunction

   task automatic flag(string what, logic [31:0] e, logic [31:0] a);
      err_count++;
      if (err_count <= MAX_REPORTS)
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, e, a);
   endtask

   // Compare one popped word against the oldest expectation
   task automatic check_word(rtpfu_pkg::rsp_type got);
      rtpfu_pkg::rsp_type want;
      if (words_due.size() == 0) begin
         err_count++;
         if (err_count <= MAX_REPORTS)
            $display("%0t ns: word with nothing expected, expected none, actual %0h",
                     $time, got);
      end else begin
         want = words_due.pop_front();
         words_out++;
         if (got.out_byte != want.out_byte)
            flag("out_byte", 32'(want.out_byte), 32'(got.out_byte));
         if (got.out_last != want.out_last)
            flag("out_last", 32'(want.out_last), 32'(got.out_last));
         if (got.status != want.status)
            flag("status", 32'(want.status), 32'(got.status));
         if (got.nal_type != want.nal_type)
            flag("nal_type", 32'(want.nal_type), 32'(got.nal_type));
         if (got.fragment_bits != want.fragment_bits)
            flag("fragment_bits", 32'(want.fragment_bits), 32'(got.fragment_bits));
         if (got.sequence_res != want.sequence_res)
            flag("sequence_res", 32'(want.sequence_res), 32'(got.sequence_res));
         if (got.timestamp != want.timestamp)
            flag("timestamp", want.timestamp, got.timestamp);
      end
   endtask

   // Push one packet byte and predict its words once it is taken
   task automatic send_byte(logic [7:0] b, logic l);
      int                 gap;
      rtpfu_pkg::req_type r;
      r.in_byte = b;
      r.in_last = l;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_full) @(posedge clock);
      depacketize_byte(r);
      bytes_in++;
   endtask

   // Hold input until every expected word is out, then let the pipe empty
   task automatic settle_results();
      req_push <= 1'b0;
      while (words_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_hb(int v);
      csr_write <= 1'b1;
      csr_data  <= v[6:0];
      @(posedge clock);
      csr_write <= 1'b0;
      hb_m = v[6:0];
   endtask

   // Build one random packet: mostly well formed, some cut short
   task automatic send_packet(output int count);
      logic [7:0] pkt[$];
      logic [7:0] ind;
      logic [7:0] fu;
      int         kind;
      int         len;
      int         i;
      kind = $urandom_range(0, 9);
      no_idle = ($urandom_range(0, 3) == 0);
      if (kind == 0) begin
         len = $urandom_range(1, hb_m);
         for (i = 0; i < len; i++) pkt.push_back(8'($urandom_range(0, 255)));
      end else begin
         for (i = 0; i < hb_m; i++) pkt.push_back(8'($urandom_range(0, 255)));
         ind = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 1)) ind[4:0] = rtpfu_pkg::FU_A_TYPE;
         pkt.push_back(ind);
         // kind 1 ends the packet on the indicator
         if (kind != 1) begin
            if (ind[4:0] == rtpfu_pkg::FU_A_TYPE) begin
               fu = 8'($urandom_range(0, 255));
               case ($urandom_range(0, 2))
                  0: fu[7:6] = FU_START_BITS;
                  1: fu[7:6] = FU_END_BITS;
                  default: ;
               endcase
               pkt.push_back(fu);
            end
            len = $urandom_range(0, 5);
            for (i = 0; i < len; i++) pkt.push_back(8'($urandom_range(0, 255)));
         end
      end
      for (i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
      count = pkt.size();
      pkt_count++;
   endtask

   task automatic run_phase(int hb_val, int quota);
      int n;
      int got;
      settle_results();
      write_hb(hb_val);
      n = 0;
      while (n < quota) begin
         send_packet(got);
         n += got;
         // pause now and then until the result side has caught up
         if ($urandom_range(0, 7) == 0) settle_results();
      end
   endtask

   task automatic add_row(logic [7:0] b, logic l, bit typed, logic [7:0] xb, logic xl,
                          rtpfu_pkg::status_type xs, int set_hb);
      pkt_row_type r;
      r.b = b; r.l = l; r.typed = typed;
      r.xb = xb; r.xl = xl; r.xs = xs; r.set_hb = set_hb;
      rows.push_back(r);
   endtask

   // Result side: pop with random stalls and check every word
   initial begin : result_side
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
         check_word(rsp_data);
      end
   end

   initial begin : input_side
      rtpfu_pkg::rsp_type w;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // after reset: one byte packet is too short
      add_row(8'hff, 1'b1, 1'b1, 8'h00, 1'b1, rtpfu_pkg::STATUS_SHORT, -1);
      // two byte header: indicator and payload overlap the captured fields
      add_row(8'h00, 1'b0, 1'b0, 8'h00, 1'b0, rtpfu_pkg::STATUS_DATA, 2);
      add_row(8'hff, 1'b0, 1'b0, 8'h00, 1'b0, rtpfu_pkg::STATUS_DATA, -1);
      add_row(8'h65, 1'b0, 1'b0, 8'h00, 1'b0, rtpfu_pkg::STATUS_DATA, -1);
      add_row(8'h00, 1'b0, 1'b0, 8'h00, 1'b0, rtpfu_pkg::STATUS_DATA, -1);
      add_row(8'hff, 1'b1, 1'b1, 8'hff, 1'b1, rtpfu_pkg::STATUS_DATA, -1);
      // start fragment with the R bit set
      add_row(8'h80, 1'b0, 1'b0, 8'h00, 1'b0, rtpfu_pkg::STATUS_DATA, -1);
      add_row(8'h7f, 1'b0, 1'b0, 8'h00, 1'b0, rtpfu_pkg::STATUS_DATA, -1);
      add_row(8'h7c, 1'b0, 1'b0, 8'h00, 1'b0, rtpfu_pkg::STATUS_DATA, -1);
      add_row(8'ha5, 1'b0, 1'b0, 8'h00, 1'b0, rtpfu_pkg::STATUS_DATA, -1);
      add_row(8'h55, 1'b1, 1'b1, 8'h55, 1'b1, rtpfu_pkg::STATUS_DATA, -1);
      // empty end fragment
      add_row(8'h11, 1'b0, 1'b0, 8'h00, 1'b0, rtpfu_pkg::STATUS_DATA, -1);
      add_row(8'h22, 1'b0, 1'b0, 8'h00, 1'b0, rtpfu_pkg::STATUS_DATA, -1);
      add_row(8'h5c, 1'b0, 1'b0, 8'h00, 1'b0, rtpfu_pkg::STATUS_DATA, -1);
      add_row(8'h45, 1'b1, 1'b1, 8'h00, 1'b1, rtpfu_pkg::STATUS_EMPTY, -1);
      // packet ends on the FU indicator
      add_row(8'h33, 1'b0, 1'b0, 8'h00, 1'b0, rtpfu_pkg::STATUS_DATA, -1);
      add_row(8'h44, 1'b0, 1'b0, 8'h00, 1'b0, rtpfu_pkg::STATUS_DATA, -1);
      add_row(8'hfc, 1'b1, 1'b1, 8'h00, 1'b1, rtpfu_pkg::STATUS_SHORT, -1);
      // empty start fragment: the rebuilt header closes the packet
      add_row(8'h00, 1'b0, 1'b0, 8'h00, 1'b0, rtpfu_pkg::STATUS_DATA, -1);
      add_row(8'h00, 1'b0, 1'b0, 8'h00, 1'b0, rtpfu_pkg::STATUS_DATA, -1);
      add_row(8'h1c, 1'b0, 1'b0, 8'h00, 1'b0, rtpfu_pkg::STATUS_DATA, -1);
      add_row(8'h9f, 1'b1, 1'b1, 8'h1f, 1'b1, rtpfu_pkg::STATUS_DATA, -1);
      // middle fragment with payload
      add_row(8'h01, 1'b0, 1'b0, 8'h00, 1'b0, rtpfu_pkg::STATUS_DATA, -1);
      add_row(8'h02, 1'b0, 1'b0, 8'h00, 1'b0, rtpfu_pkg::STATUS_DATA, -1);
      add_row(8'h3c, 1'b0, 1'b0, 8'h00, 1'b0, rtpfu_pkg::STATUS_DATA, -1);
      add_row(8'h05, 1'b0, 1'b0, 8'h00, 1'b0, rtpfu_pkg::STATUS_DATA, -1);
      add_row(8'haa, 1'b1, 1'b1, 8'haa, 1'b1, rtpfu_pkg::STATUS_DATA, -1);

      foreach (rows[i]) begin
         if (rows[i].set_hb >= 0) begin
            settle_results();
            write_hb(rows[i].set_hb);
         end
         send_byte(rows[i].b, rows[i].l);
         if (rows[i].l) pkt_count++;
         // typed values stand in for the last predicted word of the row
         if (rows[i].typed) begin
            w = words_due.pop_back();
            w.out_byte = rows[i].xb;
            w.out_last = rows[i].xl;
            w.status   = rows[i].xs;
            words_due.push_back(w);
         end
      end

      mid_hb = $urandom_range(13, 24);
      run_phase(12, 30);
      run_phase(72, 1);
      run_phase(mid_hb, 1);

      no_idle = 1'b0;
      settle_results();
      repeat (8) @(posedge clock);
      $display("Covered %0d packets, %0d input words, %0d result words checked,",
               pkt_count, bytes_in, words_out);
      $display("with header lengths 2, 12, 72 and %0d under random stalls.", mid_hb);
      if (err_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
`default_nettype wire

[sim.f]
rtl/rtpfu_pkg.sv
rtl/rtpfu_front.sv
rtl/rtpfu_cmd_fifo.sv
rtl/rtpfu_back.sv
rtl/rtp_h264_fu_depacketizer_core.sv
verif/tb.sv
